### design/qas_pkg.sv
// Package for the quoted argument scanner: payload structs, scan state
// and character and result codes. No dependencies.
`timescale 1ns / 1ps

package qas_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CAUSE_WS    = 2'd0,
    CAUSE_NUL   = 2'd1,
    CAUSE_QUOTE = 2'd2
  } cause_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       token_start;
    logic       begin_quoted;
  } qas_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] out_kind;
    logic [1:0] end_cause;
    logic       last;
  } qas_out_t;

  typedef struct packed {
    logic scanning;
    logic in_quote;
    logic pending_backslash;
    logic after_backslash_pair;
    logic started_quoted;
  } qas_state_t;

  // Depth of the result queue; it must hold two results per transaction.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic qas_out_t mk_res(input logic [7:0] c, input kind_t k, input cause_t cs);
    qas_out_t r;
    r.out_char  = c;
    r.out_kind  = k;
    r.end_cause = cs;
    r.last      = 1'b0;
    return r;
  endfunction

endpackage

### design/qas_step.sv
// Next-state and result logic of the quoted argument scanner for one
// character. Depends on qas_pkg.
`timescale 1ns / 1ps

module qas_step
  import qas_pkg::*;
(
  input  qas_state_t state,
  input  qas_in_t    item,
  output qas_state_t state_nxt,
  output qas_out_t   res0,
  output qas_out_t   res1,
  output logic [1:0] res_cnt
);

  always_comb begin
    qas_state_t s;
    qas_out_t   r [2];
    logic [1:0] n;
    logic       pair_before;
    qas_out_t   x;
    logic       have;
    logic       bs_out;

    s    = state;
    r[0] = mk_res(CH_NUL, KIND_NONE, CAUSE_WS);
    r[1] = mk_res(CH_NUL, KIND_NONE, CAUSE_WS);
    n    = 2'd0;
    pair_before = 1'b0;
    x    = mk_res(CH_NUL, KIND_NONE, CAUSE_WS);
    have = 1'b0;
    bs_out = 1'b0;

    if (item.token_start) begin
      s = '0;
      if (item.ch == CH_NUL) begin
        r[0] = mk_res(CH_NUL, KIND_NONE, CAUSE_NUL);
        n    = 2'd1;
      end else if (!item.begin_quoted && is_ws(item.ch)) begin
        r[0] = mk_res(CH_NUL, KIND_NONE, CAUSE_WS);
        n    = 2'd1;
      end else begin
        s.scanning       = 1'b1;
        s.in_quote       = item.begin_quoted;
        s.started_quoted = item.begin_quoted;
      end
    end else if (!state.scanning) begin
      r[0] = mk_res(CH_NUL, KIND_NONE, (item.ch == CH_NUL) ? CAUSE_NUL : CAUSE_WS);
      n    = 2'd1;
    end

    // Here n is zero whenever a scan is live, so the first result goes to
    // slot 0 and a second, when there is one, goes to slot 1.
    if (s.scanning) begin
      pair_before            = s.after_backslash_pair;
      s.after_backslash_pair = 1'b0;
      if (item.ch == CH_NUL || (!s.in_quote && is_ws(item.ch))) begin
        x = mk_res(CH_NUL, KIND_END, (item.ch == CH_NUL) ? CAUSE_NUL : CAUSE_WS);
        have = s.pending_backslash;
        s = '0;
      end else if (item.ch == CH_QUOTE) begin
        have = pair_before;
        if (s.pending_backslash) begin
          s.pending_backslash = 1'b0;
          x = mk_res(CH_QUOTE, KIND_CHAR, CAUSE_WS);
        end else if (s.in_quote && s.started_quoted) begin
          x = mk_res(CH_NUL, KIND_END, CAUSE_QUOTE);
          s = '0;
        end else begin
          s.in_quote = !s.in_quote;
          x = mk_res(CH_QUOTE, KIND_CHAR, CAUSE_WS);
        end
      end else if (item.ch == CH_BSLASH) begin
        if (s.pending_backslash) begin
          s.pending_backslash    = 1'b0;
          s.after_backslash_pair = 1'b1;
          bs_out                 = 1'b1;
        end else begin
          s.pending_backslash = 1'b1;
        end
      end else begin
        have = s.pending_backslash;
        s.pending_backslash = 1'b0;
        x = mk_res(item.ch, KIND_CHAR, CAUSE_WS);
      end

      // The leading backslash result, if any, always precedes the main one.
      if (item.ch == CH_BSLASH) begin
        if (bs_out) begin
          r[0] = mk_res(CH_BSLASH, KIND_CHAR, CAUSE_WS);
          n    = 2'd1;
        end
      end else if (have) begin
        r[0] = mk_res(CH_BSLASH, KIND_CHAR, CAUSE_WS);
        r[1] = x;
        n    = 2'd2;
      end else begin
        r[0] = x;
        n    = 2'd1;
      end
    end

    if (n == 2'd1) begin
      r[0].last = 1'b1;
    end else if (n == 2'd2) begin
      r[1].last = 1'b1;
    end

    state_nxt = s;
    res0      = r[0];
    res1      = r[1];
    res_cnt   = n;
  end

endmodule

### design/quoted_argument_scanner_top.sv
// Top level of the quoted argument scanner: scan state register and the
// result queue. Depends on qas_pkg and qas_step.
`timescale 1ns / 1ps
//
// Usage:
// Characters enter on the in_ channel (in_valid, in_stall, in_data), one
// transaction per character. Results leave on the out_ channel (out_valid,
// out_stall, out_data), one transaction per result. A character yields
// zero, one or two results; the last result of a character has last set.
// Each accepted character is processed in the cycle it is accepted and its
// results are written into a four-entry result queue, so when the queue was
// empty the first result appears on the outputs in the cycle after acceptance.
// A new character can be accepted in every cycle while the queue has room for
// two results; a character that yields two results sends them in turn, so
// without receiver stalls sustained throughput is one character per cycle for
// one-result characters and one result per cycle in general.
// When the receiver stalls, the head result holds on out_data and the queue
// fills; in_stall rises once fewer than two free entries remain.
// Reset empties the queue and clears the scan state, so no scan is active.

module quoted_argument_scanner_top
  import qas_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  qas_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output qas_out_t out_data
);

  qas_state_t     state_r;
  qas_state_t     state_nxt;
  qas_out_t       res0;
  qas_out_t       res1;
  logic [1:0]     res_cnt;
  qas_out_t       queue_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   count_r;
  logic [QAW:0]   count_nxt;
  logic           push;
  logic           pop;
  logic [QAW-1:0] wr_ptr_inc;

  qas_step u_step (
    .state     (state_r),
    .item      (in_data),
    .state_nxt (state_nxt),
    .res0      (res0),
    .res1      (res1),
    .res_cnt   (res_cnt)
  );

  assign in_stall   = (count_r > (QAW+1)'(QDEPTH - 2));
  assign push       = in_valid && !in_stall;
  assign out_valid  = (count_r != '0);
  assign pop        = out_valid && !out_stall;
  assign out_data   = queue_r[rd_ptr_r];
  assign wr_ptr_inc = wr_ptr_r + QAW'(1);

  always_comb begin
    count_nxt = count_r;
    if (push) begin
      count_nxt = count_nxt + {{(QAW-1){1'b0}}, res_cnt};
    end
    if (pop) begin
      count_nxt = count_nxt - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        state_r  <= state_nxt;
        wr_ptr_r <= wr_ptr_r + QAW'(res_cnt);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (res_cnt != 2'd0)) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (push && (res_cnt == 2'd2)) begin
      queue_r[wr_ptr_inc] <= res1;
    end
  end

endmodule
